// File: src/scfcr_pkg.sv
// Shared widths and types for the sphere center pipeline.
`default_nettype none
package scfcr_pkg;

   localparam int DIR_BITS = 30;
   localparam int DIR_W    = DIR_BITS + 1;
   localparam int PRD_W    = 2 * DIR_W;
   localparam int CRS_W    = PRD_W + 1;

   typedef logic signed [DIR_W-1:0] dir_type;
   typedef logic signed [PRD_W-1:0] prd_type;
   typedef logic signed [CRS_W-1:0] crs_type;

endpackage
`default_nettype wire

// File: src/scfcr_delay.sv
// Plain shift line that carries side data alongside the arithmetic stages.
`default_nettype none
module scfcr_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] q_out
);

   logic [W-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q_out = pipe_ff[DEPTH-1];

endmodule
`default_nettype wire

// File: src/scfcr_norm.sv
// Vector direction normalize: common right shift until all magnitudes fit DIR_BITS.
`default_nettype none
module scfcr_norm
   import scfcr_pkg::*;
#(
   parameter int IN_W = 33
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [IN_W-1:0] v_in [3],
   output dir_type                v_out [3]
);

   localparam int SH_W = $clog2(IN_W + 1);

   logic [IN_W-1:0]     mag [3];
   logic [IN_W-1:0]     mx;
   logic [SH_W-1:0]     sh;
   logic [DIR_BITS-1:0] m_sh [3];
   dir_type             v_in_n [3];
   dir_type             v_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = v_in[i][IN_W-1] ? (~v_in[i] + 1'b1) : v_in[i];
      end
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      sh = '0;
      for (int j = 0; j < IN_W; j++) begin
         if (mx[j] && (j >= DIR_BITS)) sh = SH_W'(j - DIR_BITS + 1);
      end
      for (int i = 0; i < 3; i++) begin
         m_sh[i]   = DIR_BITS'(mag[i] >> sh);
         v_in_n[i] = v_in[i][IN_W-1] ? -$signed({1'b0, m_sh[i]}) : $signed({1'b0, m_sh[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in_n;
      end
   end

   assign v_out = v_ff;

endmodule
`default_nettype wire

// File: src/scfcr_cross.sv
// Two-stage cross product: six products, then three differences.
`default_nettype none
module scfcr_cross
   import scfcr_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  dir_type a_in [3],
   input  dir_type b_in [3],
   output crs_type c_out [3]
);

   prd_type prod_in [6];
   prd_type prod_ff [6];
   crs_type c_in [3];
   crs_type c_ff [3];

   always_comb begin
      prod_in[0] = PRD_W'(a_in[1]) * PRD_W'(b_in[2]);
      prod_in[1] = PRD_W'(a_in[2]) * PRD_W'(b_in[1]);
      prod_in[2] = PRD_W'(a_in[2]) * PRD_W'(b_in[0]);
      prod_in[3] = PRD_W'(a_in[0]) * PRD_W'(b_in[2]);
      prod_in[4] = PRD_W'(a_in[0]) * PRD_W'(b_in[1]);
      prod_in[5] = PRD_W'(a_in[1]) * PRD_W'(b_in[0]);
      for (int k = 0; k < 3; k++) begin
         c_in[k] = CRS_W'(prod_ff[2*k]) - CRS_W'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         c_ff    <= c_in;
      end
   end

   assign c_out = c_ff;

endmodule
`default_nettype wire

// File: src/scfcr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module scfcr_isqrt #(
   parameter int OUT_W = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [2*OUT_W-1:0]   n_in,
   output logic [OUT_W-1:0]     root_out
);

   localparam int IN_W  = 2 * OUT_W;
   localparam int REM_W = OUT_W + 3;

   logic [REM_W-1:0] rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic [IN_W-1:0]  rest_ff [OUT_W];
   logic [REM_W-1:0] rem_in  [OUT_W];
   logic [OUT_W-1:0] root_in [OUT_W];
   logic [IN_W-1:0]  rest_in [OUT_W];

   always_comb begin
      logic [REM_W-1:0] s_rem;
      logic [OUT_W-1:0] s_root;
      logic [IN_W-1:0]  s_rest;
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      logic             ge;
      for (int k = 0; k < OUT_W; k++) begin
         if (k == 0) begin
            s_rem  = '0;
            s_root = '0;
            s_rest = n_in;
         end else begin
            s_rem  = rem_ff[k-1];
            s_root = root_ff[k-1];
            s_rest = rest_ff[k-1];
         end
         cur        = {s_rem[REM_W-3:0], s_rest[IN_W-1:IN_W-2]};
         trial      = REM_W'({s_root, 2'b01});
         ge         = cur >= trial;
         rem_in[k]  = ge ? (cur - trial) : cur;
         root_in[k] = {s_root[OUT_W-2:0], ge};
         rest_in[k] = {s_rest[IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rest_ff <= rest_in;
      end
   end

   assign root_out = root_ff[OUT_W-1];

endmodule
`default_nettype wire

// File: src/scfcr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module scfcr_div #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 32,
   parameter int Q_W   = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [Q_W-1:0]   q_out
);

   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   low_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [DEN_W-1:0] rem_in [Q_W];
   logic [Q_W-1:0]   low_in [Q_W];
   logic [DEN_W-1:0] den_in_s [Q_W];

   always_comb begin
      logic [DEN_W-1:0] s_rem;
      logic [Q_W-1:0]   s_low;
      logic [DEN_W-1:0] s_den;
      logic [DEN_W:0]   cur;
      logic             ge;
      for (int k = 0; k < Q_W; k++) begin
         if (k == 0) begin
            s_rem = DEN_W'(num_in >> Q_W);
            s_low = num_in[Q_W-1:0];
            s_den = den_in;
         end else begin
            s_rem = rem_ff[k-1];
            s_low = low_ff[k-1];
            s_den = den_ff[k-1];
         end
         cur         = {s_rem, s_low[Q_W-1]};
         ge          = cur >= {1'b0, s_den};
         rem_in[k]   = ge ? DEN_W'(cur - {1'b0, s_den}) : DEN_W'(cur);
         low_in[k]   = {s_low[Q_W-2:0], ge};
         den_in_s[k] = s_den;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         den_ff <= den_in_s;
      end
   end

   assign q_out = low_ff[Q_W-1];

endmodule
`default_nettype wire

// File: src/sphere_center_from_chord_and_radius.sv
// Top level: sphere center from chord endpoints and a radius vector, fully pipelined.
// Takes one word per cycle while the pipeline advances and returns one word per input.
// Most of the pipeline depth lies in the two bit-per-stage square root units (RW stages,
// where RW = max(COORD_BITS, 32)) and the three bit-per-stage dividers (COORD_BITS
// stages). The whole pipeline holds while a result waits on rsp_ready; req_ready is
// low only then. No stored state between words.
`default_nettype none
module sphere_center_from_chord_and_radius
   import scfcr_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_a_x,
   input  logic signed [COORD_BITS-1:0] req_point_a_y,
   input  logic signed [COORD_BITS-1:0] req_point_a_z,
   input  logic signed [COORD_BITS-1:0] req_point_b_x,
   input  logic signed [COORD_BITS-1:0] req_point_b_y,
   input  logic signed [COORD_BITS-1:0] req_point_b_z,
   input  logic signed [COORD_BITS-1:0] req_radius_x,
   input  logic signed [COORD_BITS-1:0] req_radius_y,
   input  logic signed [COORD_BITS-1:0] req_radius_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_center_x,
   output logic signed [COORD_BITS-1:0] rsp_center_y,
   output logic signed [COORD_BITS-1:0] rsp_center_z,
   output logic                         rsp_midpoint_only
);

   localparam int C      = COORD_BITS;
   localparam int RW     = (C > 32) ? C : 32;
   localparam int SQ_W   = 2 * RW;
   localparam int SQR_W  = 2 * C + 2;
   localparam int SUM_W  = 2 * C + 3;
   localparam int PM_W   = RW + DIR_BITS;
   localparam int NUM_W  = PM_W + 1;
   localparam int LAT    = 13 + RW + C;
   localparam int M_DLY  = 11 + RW + C;
   localparam int S_DLY  = 8 + RW + C;
   localparam int PS_DLY = 2 + RW;
   localparam int SB_DLY = 2 + C;

   logic adv;
   logic [LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: midpoint, chord, half chord
   logic signed [C-1:0] a_w [3];
   logic signed [C-1:0] b_w [3];
   logic signed [C-1:0] r_w [3];
   logic signed [C:0]   sum_w [3];
   logic signed [C-1:0] m1_in [3];
   logic signed [C:0]   d1_in [3];
   logic signed [C:0]   h1_in [3];
   logic signed [C-1:0] m1_ff [3];
   logic signed [C:0]   d1_ff [3];
   logic signed [C:0]   h1_ff [3];
   logic signed [C-1:0] r1_ff [3];

   assign a_w[0] = req_point_a_x;
   assign a_w[1] = req_point_a_y;
   assign a_w[2] = req_point_a_z;
   assign b_w[0] = req_point_b_x;
   assign b_w[1] = req_point_b_y;
   assign b_w[2] = req_point_b_z;
   assign r_w[0] = req_radius_x;
   assign r_w[1] = req_radius_y;
   assign r_w[2] = req_radius_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_w[i] = (C+1)'(a_w[i]) + (C+1)'(b_w[i]);
         m1_in[i] = sum_w[i][C:1];
         d1_in[i] = (C+1)'(b_w[i]) - (C+1)'(a_w[i]);
         h1_in[i] = (C+1)'(a_w[i]) - (C+1)'(m1_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         d1_ff <= d1_in;
         h1_ff <= h1_in;
         r1_ff <= r_w;
      end
   end

   // stage 2: squares; directions of h and r
   logic signed [SQR_W-1:0] rsq2_in [3];
   logic signed [SQR_W-1:0] dsq2_in [3];
   logic signed [SQR_W-1:0] hsq2_in [3];
   logic signed [SQR_W-1:0] rsq2_ff [3];
   logic signed [SQR_W-1:0] dsq2_ff [3];
   logic signed [SQR_W-1:0] hsq2_ff [3];
   dir_type hs2 [3];
   dir_type rs2 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsq2_in[i] = SQR_W'(r1_ff[i]) * SQR_W'(r1_ff[i]);
         dsq2_in[i] = SQR_W'(d1_ff[i]) * SQR_W'(d1_ff[i]);
         hsq2_in[i] = SQR_W'(h1_ff[i]) * SQR_W'(h1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsq2_ff <= rsq2_in;
         dsq2_ff <= dsq2_in;
         hsq2_ff <= hsq2_in;
      end
   end

   scfcr_norm #(.IN_W(C + 1)) u_norm_h (
      .clock(clock), .en(adv), .v_in(h1_ff), .v_out(hs2)
   );

   scfcr_norm #(.IN_W(C)) u_norm_r (
      .clock(clock), .en(adv), .v_in(r1_ff), .v_out(rs2)
   );

   // stage 3: sums of squares
   logic [SUM_W-1:0] r2_3_in, d2_3_in, h2_3_in;
   logic [SUM_W-1:0] r2_3_ff, d2_3_ff, h2_3_ff;

   always_comb begin
      r2_3_in = SUM_W'($unsigned(rsq2_ff[0])) + SUM_W'($unsigned(rsq2_ff[1]))
              + SUM_W'($unsigned(rsq2_ff[2]));
      d2_3_in = SUM_W'($unsigned(dsq2_ff[0])) + SUM_W'($unsigned(dsq2_ff[1]))
              + SUM_W'($unsigned(dsq2_ff[2]));
      h2_3_in = SUM_W'($unsigned(hsq2_ff[0])) + SUM_W'($unsigned(hsq2_ff[1]))
              + SUM_W'($unsigned(hsq2_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_3_ff <= r2_3_in;
         d2_3_ff <= d2_3_in;
         h2_3_ff <= h2_3_in;
      end
   end

   // stage 4: short-radius test, offset length squared
   logic            short4_in, short4_ff;
   logic [SQ_W-1:0] diff4_in, diff4_ff;

   always_comb begin
      short4_in = r2_3_ff <= d2_3_ff;
      diff4_in  = (r2_3_ff > h2_3_ff) ? SQ_W'(r2_3_ff - h2_3_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         short4_ff <= short4_in;
         diff4_ff  <= diff4_in;
      end
   end

   // direction chain: n = h x r, p = n x h
   crs_type n4 [3];
   dir_type ns5 [3];
   dir_type hs5 [3];
   crs_type p7 [3];
   dir_type ps8 [3];
   logic [3*DIR_W-1:0] hs2_pk, hs5_pk;

   scfcr_cross u_cross_n (
      .clock(clock), .en(adv), .a_in(hs2), .b_in(rs2), .c_out(n4)
   );

   scfcr_norm #(.IN_W(CRS_W)) u_norm_n (
      .clock(clock), .en(adv), .v_in(n4), .v_out(ns5)
   );

   assign hs2_pk = {hs2[2], hs2[1], hs2[0]};

   scfcr_delay #(.W(3 * DIR_W), .DEPTH(3)) u_dly_hs (
      .clock(clock), .en(adv), .d_in(hs2_pk), .q_out(hs5_pk)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hs5[i] = hs5_pk[i*DIR_W +: DIR_W];
      end
   end

   scfcr_cross u_cross_p (
      .clock(clock), .en(adv), .a_in(ns5), .b_in(hs5), .c_out(p7)
   );

   scfcr_norm #(.IN_W(CRS_W)) u_norm_p (
      .clock(clock), .en(adv), .v_in(p7), .v_out(ps8)
   );

   // stages 9-10: |p|^2
   prd_type         psq9_in [3];
   prd_type         psq9_ff [3];
   logic [SQ_W-1:0] pp10_in, pp10_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psq9_in[i] = PRD_W'(ps8[i]) * PRD_W'(ps8[i]);
      end
      pp10_in = SQ_W'($unsigned(psq9_ff[0])) + SQ_W'($unsigned(psq9_ff[1]))
              + SQ_W'($unsigned(psq9_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         psq9_ff <= psq9_in;
         pp10_ff <= pp10_in;
      end
   end

   // square roots
   logic [SQ_W-1:0] diff10;
   logic [RW-1:0]   blen, len;

   scfcr_delay #(.W(SQ_W), .DEPTH(6)) u_dly_diff (
      .clock(clock), .en(adv), .d_in(diff4_ff), .q_out(diff10)
   );

   scfcr_isqrt #(.OUT_W(RW)) u_sqrt_b (
      .clock(clock), .en(adv), .n_in(diff10), .root_out(blen)
   );

   scfcr_isqrt #(.OUT_W(RW)) u_sqrt_l (
      .clock(clock), .en(adv), .n_in(pp10_ff), .root_out(len)
   );

   // offset scaling
   logic [3*DIR_W-1:0]  ps8_pk, psr_pk;
   dir_type             psr [3];
   logic [DIR_BITS-1:0] psmag [3];
   logic [3:0]          sb_in, sb;
   logic [PM_W-1:0]     nprod_in [3];
   logic [PM_W-1:0]     nprod_ff [3];
   logic [RW-1:0]       len1_ff;
   logic [NUM_W-1:0]    numh_in [3];
   logic [NUM_W-1:0]    numh_ff [3];
   logic [C-1:0]        q [3];

   assign ps8_pk = {ps8[2], ps8[1], ps8[0]};

   scfcr_delay #(.W(3 * DIR_W), .DEPTH(PS_DLY)) u_dly_ps (
      .clock(clock), .en(adv), .d_in(ps8_pk), .q_out(psr_pk)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psr[i]      = psr_pk[i*DIR_W +: DIR_W];
         psmag[i]    = psr[i][DIR_BITS] ? DIR_BITS'(-psr[i]) : DIR_BITS'(psr[i]);
         sb_in[i]    = psr[i][DIR_BITS];
         nprod_in[i] = PM_W'(blen) * PM_W'(psmag[i]);
         numh_in[i]  = NUM_W'(nprod_ff[i]) + NUM_W'(len1_ff >> 1);
      end
      sb_in[3] = len == '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nprod_ff <= nprod_in;
         len1_ff  <= len;
         numh_ff  <= numh_in;
      end
   end

   scfcr_delay #(.W(4), .DEPTH(SB_DLY)) u_dly_sb (
      .clock(clock), .en(adv), .d_in(sb_in), .q_out(sb)
   );

   logic [RW-1:0] len_d;

   scfcr_delay #(.W(RW), .DEPTH(1)) u_dly_len (
      .clock(clock), .en(adv), .d_in(len1_ff), .q_out(len_d)
   );

   generate
      for (genvar g = 0; g < 3; g++) begin : g_div
         scfcr_div #(.NUM_W(NUM_W), .DEN_W(RW), .Q_W(C)) u_div (
            .clock(clock), .en(adv), .num_in(numh_ff[g]), .den_in(len_d), .q_out(q[g])
         );
      end
   endgenerate

   // midpoint and flag carried to the end
   logic [3*C-1:0]      m1_pk, md_pk;
   logic signed [C-1:0] md [3];
   logic                sd;

   assign m1_pk = {m1_ff[2], m1_ff[1], m1_ff[0]};

   scfcr_delay #(.W(3 * C), .DEPTH(M_DLY)) u_dly_m (
      .clock(clock), .en(adv), .d_in(m1_pk), .q_out(md_pk)
   );

   scfcr_delay #(.W(1), .DEPTH(S_DLY)) u_dly_short (
      .clock(clock), .en(adv), .d_in(short4_ff), .q_out(sd)
   );

   // output stage: add offset, saturate; midpoint alone when the radius is short
   localparam logic signed [C-1:0] MAX_V = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] MIN_V = {1'b1, {(C-1){1'b0}}};

   logic signed [C:0]   off_w [3];
   logic signed [C+1:0] tot_w [3];
   logic signed [C-1:0] cen_in [3];
   logic signed [C-1:0] cen_ff [3];
   logic                flag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         md[i] = md_pk[i*C +: C];
         if (sb[3]) begin
            off_w[i] = '0;
         end else begin
            off_w[i] = sb[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
         end
         tot_w[i] = (C+2)'(md[i]) + (C+2)'(off_w[i]);
         if (sd) begin
            cen_in[i] = md[i];
         end else if ((tot_w[i][C+1:C-1] != 3'b000) && (tot_w[i][C+1:C-1] != 3'b111)) begin
            cen_in[i] = tot_w[i][C+1] ? MIN_V : MAX_V;
         end else begin
            cen_in[i] = tot_w[i][C-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cen_ff  <= cen_in;
         flag_ff <= sd;
      end
   end

   assign rsp_center_x      = cen_ff[0];
   assign rsp_center_y      = cen_ff[1];
   assign rsp_center_z      = cen_ff[2];
   assign rsp_midpoint_only = flag_ff;

endmodule
`default_nettype wire

// File: sim/sphere_center_from_chord_and_radius_tb.sv
// Testbench for the sphere center pipeline: random and directed words, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module sphere_center_from_chord_and_radius_tb
   import scfcr_pkg::*;
();

   localparam int COORD_BITS = 32;
   localparam int RAND_WORDS = 1000;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef longint vec3_type [3];

   typedef struct {
      coord_type cx, cy, cz;
      logic      mid_only;
   } center_word_type;

   typedef struct {
      coord_type ax, ay, az, bx, by, bz, rx, ry, rz;
   } chord_word_type;

   class center_scoreboard;
      center_word_type pending[$];
      int errors = 0;

      function automatic logic [63:0] magn(longint v);
         return v < 0 ? 64'd0 - 64'(v) : 64'(v);
      endfunction

      function automatic logic [127:0] norm_sq(vec3_type v);
         logic [127:0] s = 0;
         for (int i = 0; i < 3; i++) s += {64'd0, magn(v[i])} * {64'd0, magn(v[i])};
         return s;
      endfunction

      function automatic logic [63:0] isqrt128(logic [127:0] n);
         logic [63:0] r = 0, t;
         for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= n) r = t;
         end
         return r;
      endfunction

      function automatic vec3_type shrink(vec3_type v);
         logic [63:0] mx = 0;
         int sh = 0;
         vec3_type o;
         for (int i = 0; i < 3; i++) if (magn(v[i]) > mx) mx = magn(v[i]);
         while ((mx >> sh) >= (64'd1 << DIR_BITS)) sh++;
         for (int i = 0; i < 3; i++)
            o[i] = v[i] < 0 ? -longint'(magn(v[i]) >> sh) : longint'(magn(v[i]) >> sh);
         return o;
      endfunction

      function automatic vec3_type cross3(vec3_type a, vec3_type b);
         vec3_type o;
         o[0] = a[1] * b[2] - a[2] * b[1];
         o[1] = a[2] * b[0] - a[0] * b[2];
         o[2] = a[0] * b[1] - a[1] * b[0];
         return o;
      endfunction

      function automatic coord_type clamp(longint v);
         if (v > 64'sd2147483647) return coord_type'(32'h7fffffff);
         if (v < -64'sd2147483648) return coord_type'(32'h80000000);
         return coord_type'(v);
      endfunction

      function automatic void note_chord(chord_word_type w);
         vec3_type a, b, r, m, d, h, hs, rs, ns, ps;
         logic [127:0] r2, h2, num, q;
         logic [63:0] blen, pp, len, t;
         longint off;
         center_word_type e;
         a = '{w.ax, w.ay, w.az};
         b = '{w.bx, w.by, w.bz};
         r = '{w.rx, w.ry, w.rz};
         for (int i = 0; i < 3; i++) begin
            m[i] = (a[i] + b[i]) >>> 1;
            d[i] = b[i] - a[i];
            h[i] = a[i] - m[i];
         end
         r2 = norm_sq(r);
         if (r2 <= norm_sq(d)) begin
            e = '{clamp(m[0]), clamp(m[1]), clamp(m[2]), 1'b1};
         end else begin
            h2   = norm_sq(h);
            blen = r2 <= h2 ? 64'd0 : isqrt128(r2 - h2);
            hs   = shrink(h);
            rs   = shrink(r);
            ns   = shrink(cross3(hs, rs));
            ps   = shrink(cross3(ns, hs));
            pp   = magn(ps[0]) * magn(ps[0]) + magn(ps[1]) * magn(ps[1])
                 + magn(ps[2]) * magn(ps[2]);
            len  = 0;
            for (int i = 31; i >= 0; i--) begin
               t = len | (64'd1 << i);
               if (t * t <= pp) len = t;
            end
            for (int i = 0; i < 3; i++) begin
               off = 0;
               if (len != 0) begin
                  num = {64'd0, blen} * {64'd0, magn(ps[i])} + {64'd0, len >> 1};
                  q   = num / {64'd0, len};
                  off = ps[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
               end
               m[i] = m[i] + off;
            end
            e = '{clamp(m[0]), clamp(m[1]), clamp(m[2]), 1'b0};
         end
         pending.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_center(center_word_type got);
         center_word_type e;
         if (pending.size() == 0) begin
            report("unexpected word", got.cx, 0);
            return;
         end
         e = pending.pop_front();
         if (got.cx !== e.cx) report("center_x", got.cx, e.cx);
         if (got.cy !== e.cy) report("center_y", got.cy, e.cy);
         if (got.cz !== e.cz) report("center_z", got.cz, e.cz);
         if (got.mid_only !== e.mid_only) report("midpoint_only", got.mid_only, e.mid_only);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0, rsp_midpoint_only;
   coord_type req_point_a_x = 0, req_point_a_y = 0, req_point_a_z = 0;
   coord_type req_point_b_x = 0, req_point_b_y = 0, req_point_b_z = 0;
   coord_type req_radius_x = 0, req_radius_y = 0, req_radius_z = 0;
   coord_type rsp_center_x, rsp_center_y, rsp_center_z;
   center_scoreboard sb = new();
   bit sending_done = 0;

   sphere_center_from_chord_and_radius #(.COORD_BITS(COORD_BITS)) i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int draw_gap(int idx);
      return ((idx / 64) % 3 == 0) ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic coord_type rand_coord();
      coord_type v = coord_type'($urandom);
      return v >>> $urandom_range(0, 31);
   endfunction

   task send_chord(chord_word_type w, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_point_a_x <= w.ax; req_point_a_y <= w.ay; req_point_a_z <= w.az;
      req_point_b_x <= w.bx; req_point_b_y <= w.by; req_point_b_z <= w.bz;
      req_radius_x  <= w.rx; req_radius_y  <= w.ry; req_radius_z  <= w.rz;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_chord(w);
      @(negedge clock);
   endtask

   function automatic chord_word_type random_chord();
      chord_word_type w;
      int kind = $urandom_range(0, 9);
      w.ax = rand_coord(); w.ay = rand_coord(); w.az = rand_coord();
      w.bx = rand_coord(); w.by = rand_coord(); w.bz = rand_coord();
      w.rx = rand_coord(); w.ry = rand_coord(); w.rz = rand_coord();
      if (kind < 6) begin
         // small chord, long radius: the offset path
         w.bx = w.ax + (coord_type'($urandom) >>> $urandom_range(8, 31));
         w.by = w.ay + (coord_type'($urandom) >>> $urandom_range(8, 31));
         w.bz = w.az + (coord_type'($urandom) >>> $urandom_range(8, 31));
         w.rx = coord_type'($urandom) >>> $urandom_range(0, 6);
      end else if (kind == 6) begin
         w.bx = w.ax; w.by = w.ay; w.bz = w.az;
      end else if (kind == 7) begin
         w.bx = w.ax + 16; w.by = w.ay; w.bz = w.az;
         w.rx = coord_type'($urandom_range(0, 1) ? 32'h40000000 : 32'hc0000000);
         w.ry = 0; w.rz = 0;
      end
      return w;
   endfunction

   initial begin
      chord_word_type dir_list[$];
      coord_type mx = 32'h7fffffff, mn = 32'h80000000;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      dir_list = '{
         '{0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{mx, mx, mx, mx, mx, mx, mx, mx, mx},
         '{mn, mn, mn, mn, mn, mn, mn, mn, mn},
         '{mn, mn, mn, mx, mx, mx, mx, 0, 0},
         '{mx, 0, 0, mn, 0, 0, 0, mn, 0},
         '{0, 0, 0, 65536, 0, 0, 0, 65536, 0},
         '{0, 0, 0, 65536, 0, 0, 0, 1000000, 0},
         '{5, 5, 5, 5, 5, 5, 100, 200, 300},
         '{0, 0, 0, 1, 0, 0, 0, 0, 0},
         '{0, 0, 0, 1000, 0, 0, 5000000, 0, 0},
         '{-3, 7, -1, 4, -2, 9, 0, 0, mx},
         '{mx, mx, mx, mx - 2, mx, mx, mn, mn, mn},
         '{mn, 0, mx, mn + 4, 0, mx, 1, 1, mx},
         '{-1, -1, -1, 0, 0, 0, mn, mx, mn},
         '{123456, -98765, 4321, 123400, -98700, 4300, -7, mx, 77}
      };
      foreach (dir_list[i]) send_chord(dir_list[i], i % 3);
      for (int i = 0; i < RAND_WORDS; i++) send_chord(random_chord(), draw_gap(i));
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      int gap, n = 0;
      @(negedge clock);
      while (!sending_done || sb.pending.size() != 0) begin
         gap = draw_gap(n + 32);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid && !(sending_done && sb.pending.size() == 0)) @(posedge clock);
         if (rsp_valid) begin
            sb.check_center('{rsp_center_x, rsp_center_y, rsp_center_z, rsp_midpoint_only});
            n++;
         end
         @(negedge clock);
      end
      repeat (100) begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_center('{rsp_center_x, rsp_center_y, rsp_center_z, rsp_midpoint_only});
      end
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
src/scfcr_pkg.sv
src/scfcr_delay.sv
src/scfcr_norm.sv
src/scfcr_cross.sv
src/scfcr_isqrt.sv
src/scfcr_div.sv
src/sphere_center_from_chord_and_radius.sv
sim/sphere_center_from_chord_and_radius_tb.sv
